### rtl/rtcfe_pkg.sv
// Shared types, register map codes and BCD helpers for the RTC register front end.
`timescale 1ns / 1ps
`default_nettype none

package rtcfe_pkg;

    localparam int NVRAM_BYTES = 114;
    localparam int NVRAM_AW    = (NVRAM_BYTES > 1) ? $clog2(NVRAM_BYTES) : 1;

    typedef enum logic [2:0] {
        CMD_READ   = 3'd0,
        CMD_WRITE  = 3'd1,
        CMD_ALARM  = 3'd2,
        CMD_UPDATE = 3'd3,
        CMD_TICK   = 3'd4
    } cmd_e;

    // Register map, index = addr / 4
    localparam logic [6:0] REG_SEC     = 7'd0;
    localparam logic [6:0] REG_ASEC    = 7'd1;
    localparam logic [6:0] REG_MIN     = 7'd2;
    localparam logic [6:0] REG_AMIN    = 7'd3;
    localparam logic [6:0] REG_HOUR    = 7'd4;
    localparam logic [6:0] REG_AHOUR   = 7'd5;
    localparam logic [6:0] REG_WEEKDAY = 7'd6;
    localparam logic [6:0] REG_DATE    = 7'd7;
    localparam logic [6:0] REG_MONTH   = 7'd8;
    localparam logic [6:0] REG_YEAR    = 7'd9;
    localparam logic [6:0] REG_CTRL_A  = 7'd10;
    localparam logic [6:0] REG_CTRL_B  = 7'd11;
    localparam logic [6:0] REG_CTRL_C  = 7'd12;
    localparam logic [6:0] REG_CTRL_D  = 7'd13;
    localparam logic [6:0] NVRAM_BASE  = 7'd14;

    // Control B bits
    localparam int MB_PIE = 6;
    localparam int MB_AIE = 5;
    localparam int MB_UIE = 4;
    localparam int MB_DM  = 2;
    localparam int MB_24H = 1;
    localparam logic [7:0] MODE_RESET = 8'h06;

    // Control C flag bits (stored as a 4-bit field)
    localparam int EF_IRQF = 3;
    localparam int EF_PF   = 2;
    localparam int EF_AF   = 1;
    localparam int EF_UF   = 0;

    localparam logic [7:0] CTRL_D_VALUE = 8'h80;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [23:0] addr;
        logic [2:0]  access_size;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       handled;
        logic       irq_out;
    } rsp_t;

    typedef struct packed {
        logic                en;
        logic [NVRAM_AW-1:0] addr;
    } nv_rd_t;

    typedef struct packed {
        logic                en;
        logic [NVRAM_AW-1:0] addr;
        logic [7:0]          data;
    } nv_wr_t;

    // binary -> BCD; v/10 via multiply by 205 >> 11 (exact for 8-bit v)
    function automatic logic [8:0] enc_bcd(input logic [7:0] v);
        logic [15:0] prod;
        logic [4:0]  q;
        logic [7:0]  r;
        prod = 16'(v) * 16'd205;
        q    = prod[15:11];
        r    = v - (8'(q) * 8'd10);
        return {q, r[3:0]};
    endfunction

    // BCD -> binary, non-BCD nibbles pass through the same formula
    function automatic logic [7:0] dec_bcd(input logic [7:0] v);
        return (8'(v[7:4]) * 8'd10) + 8'(v[3:0]);
    endfunction

    function automatic logic [15:0] tick_top(input logic [3:0] rate);
        logic [15:0] top;
        case (rate)
            4'd1:    top = 16'd124;
            4'd2:    top = 16'd249;
            4'd3:    top = 16'd3;
            4'd4:    top = 16'd7;
            4'd5:    top = 16'd15;
            4'd6:    top = 16'd30;
            4'd7:    top = 16'd62;
            4'd8:    top = 16'd124;
            4'd9:    top = 16'd249;
            4'd10:   top = 16'd499;
            4'd11:   top = 16'd999;
            4'd12:   top = 16'd1999;
            4'd13:   top = 16'd3999;
            4'd14:   top = 16'd7999;
            4'd15:   top = 16'd15999;
            default: top = 16'hffff;
        endcase
        return top;
    endfunction

    function automatic logic bus_ok(input req_t r);
        return (r.cmd == CMD_READ || r.cmd == CMD_WRITE) && (r.access_size == 3'd1)
            && (r.addr[1:0] == 2'b00) && (r.addr[23:9] == '0);
    endfunction

    function automatic logic nv_hit(input logic [6:0] idx);
        logic [6:0] n;
        n = idx - NVRAM_BASE;
        return (idx >= NVRAM_BASE) && ({1'b0, n} < 8'(NVRAM_BYTES));
    endfunction

    function automatic logic [NVRAM_AW-1:0] nv_addr(input logic [6:0] idx);
        logic [6:0] n;
        n = idx - NVRAM_BASE;
        return n[NVRAM_AW-1:0];
    endfunction

    // Stored 24-hour BCD hour -> bus byte
    function automatic logic [7:0] hour_to_bus(input logic [5:0] h, input logic h24,
                                               input logic dm);
        logic [7:0] t;
        logic [8:0] e;
        logic [7:0] low;
        t = {2'b00, h};
        e = enc_bcd(dec_bcd({2'b00, h}) - 8'd12);
        if (!h24) begin
            if (h == 6'h00)
                t = 8'h12;
            else if (h == 6'h12)
                t = 8'h92;
            else if (h > 6'h12)
                t = {1'b1, e[6:0]};
        end
        low = dm ? dec_bcd({1'b0, t[6:0]}) : {1'b0, t[6:0]};
        return {t[7], low[6:0]};
    endfunction

    // Bus byte -> stored 24-hour BCD hour
    function automatic logic [5:0] hour_from_bus(input logic [7:0] d, input logic h24,
                                                 input logic dm);
        logic [8:0] t0;
        logic [8:0] t1;
        logic [8:0] pm;
        t0 = dm ? enc_bcd({1'b0, d[6:0]}) : {2'b00, d[6:0]};
        t1 = (t0 == 9'h012) ? 9'h000 : t0;
        pm = enc_bcd(dec_bcd(t1[7:0]) + 8'd12);
        if (h24)
            return t0[5:0];
        else if (d[7])
            return pm[5:0];
        else
            return t1[5:0];
    endfunction

endpackage

`default_nettype wire

### rtl/rtcfe_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none

module rtcfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/rtcfe_nvram.sv
// Battery RAM array: memory, per-byte valid bits for reset-to-zero, write forwarding.
`timescale 1ns / 1ps
`default_nettype none

module rtcfe_nvram (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rtcfe_pkg::nv_rd_t rd,
    input  wire rtcfe_pkg::nv_wr_t wr,
    output logic [7:0]             rdata
);

    logic [rtcfe_pkg::NVRAM_BYTES-1:0] valid_reg;
    logic [rtcfe_pkg::NVRAM_AW-1:0]    addr_reg;
    logic                              fwd_reg;
    logic [7:0]                        fwd_data_reg;
    logic [7:0]                        ram_q;

    rtcfe_ram #(
        .WIDTH (8),
        .DEPTH (rtcfe_pkg::NVRAM_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd.en),
        .raddr (rd.addr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
            fwd_reg   <= 1'b0;
        end else begin
            if (wr.en)
                valid_reg[wr.addr] <= 1'b1;
            if (rd.en)
                fwd_reg <= wr.en && (wr.addr == rd.addr);
        end
    end

    // write landing in the same cycle as the read: RAM returns old data
    always_ff @(posedge clk)
    begin
        if (rd.en) begin
            addr_reg     <= rd.addr;
            fwd_data_reg <= wr.data;
        end
    end

    always_comb
    begin
        if (fwd_reg)
            rdata = fwd_data_reg;
        else if (valid_reg[addr_reg])
            rdata = ram_q;
        else
            rdata = 8'h00;
    end

    a_fwd_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rd.en && wr.en && (wr.addr == rd.addr)) |=> (rdata == $past(wr.data)))
        else $error("nvram read-after-write forwarding returned stale data");

endmodule

`default_nettype wire

### rtl/rtcfe_regs.sv
// Clock/alarm/control registers, bus decode and event flag logic.
`timescale 1ns / 1ps
`default_nettype none

module rtcfe_regs (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              commit,
    input  wire rtcfe_pkg::req_t   item,
    input  wire logic [7:0]        nv_rdata,
    output rtcfe_pkg::rsp_t        result,
    output rtcfe_pkg::nv_wr_t      nv_wr
);

    logic [6:0]  sec_reg, sec_next;
    logic [6:0]  min_reg, min_next;
    logic [5:0]  hour_reg, hour_next;
    logic [6:0]  asec_reg, asec_next;
    logic [6:0]  amin_reg, amin_next;
    logic [5:0]  ahour_reg, ahour_next;
    logic [2:0]  weekday_reg, weekday_next;
    logic [5:0]  date_reg, date_next;
    logic [4:0]  month_reg, month_next;
    logic [7:0]  year_reg, year_next;
    logic [3:0]  rate_reg, rate_next;
    logic [2:0]  divider_reg, divider_next;
    logic [7:0]  mode_reg, mode_next;
    logic [3:0]  flags_reg, flags_next;
    logic [15:0] tick_reg, tick_next;

    logic [6:0]  idx;
    logic        ok;
    logic        is_wr;
    logic        dm;
    logic        h24;
    logic [8:0]  store_val;
    logic [5:0]  hour_wr_val;
    logic [7:0]  field_raw;
    logic [7:0]  field_bus;
    logic [7:0]  hour_bus;
    logic        tick_fire;
    logic        clr_flags;
    logic [7:0]  rd;
    logic        handled;

    assign idx   = item.addr[8:2];
    assign ok    = rtcfe_pkg::bus_ok(item);
    assign is_wr = (item.cmd == rtcfe_pkg::CMD_WRITE);
    assign dm    = mode_reg[rtcfe_pkg::MB_DM];
    assign h24   = mode_reg[rtcfe_pkg::MB_24H];

    assign store_val   = dm ? rtcfe_pkg::enc_bcd(item.write_data) : {1'b0, item.write_data};
    assign hour_wr_val = rtcfe_pkg::hour_from_bus(item.write_data, h24, dm);
    assign hour_bus    = rtcfe_pkg::hour_to_bus((idx == rtcfe_pkg::REG_AHOUR) ? ahour_reg
                                                                               : hour_reg,
                                                h24, dm);
    assign tick_fire   = (tick_reg >= rtcfe_pkg::tick_top(rate_reg));

    always_comb
    begin
        unique case (idx)
            rtcfe_pkg::REG_SEC:     field_raw = {1'b0, sec_reg};
            rtcfe_pkg::REG_ASEC:    field_raw = {1'b0, asec_reg};
            rtcfe_pkg::REG_MIN:     field_raw = {1'b0, min_reg};
            rtcfe_pkg::REG_AMIN:    field_raw = {1'b0, amin_reg};
            rtcfe_pkg::REG_WEEKDAY: field_raw = {5'b0, weekday_reg};
            rtcfe_pkg::REG_DATE:    field_raw = {2'b0, date_reg};
            rtcfe_pkg::REG_MONTH:   field_raw = {3'b0, month_reg};
            default:                field_raw = year_reg;
        endcase
        field_bus = dm ? rtcfe_pkg::dec_bcd(field_raw) : field_raw;
    end

    always_comb
    begin
        sec_next     = sec_reg;
        min_next     = min_reg;
        hour_next    = hour_reg;
        asec_next    = asec_reg;
        amin_next    = amin_reg;
        ahour_next   = ahour_reg;
        weekday_next = weekday_reg;
        date_next    = date_reg;
        month_next   = month_reg;
        year_next    = year_reg;
        rate_next    = rate_reg;
        divider_next = divider_reg;
        mode_next    = mode_reg;
        flags_next   = flags_reg;
        tick_next    = tick_reg;
        nv_wr        = '0;
        rd           = 8'h00;
        handled      = 1'b0;
        clr_flags    = 1'b0;

        case (item.cmd) inside
            rtcfe_pkg::CMD_READ, rtcfe_pkg::CMD_WRITE: begin
                if (ok) begin
                    handled = 1'b1;
                    unique case (idx)
                        rtcfe_pkg::REG_SEC:
                            if (is_wr) sec_next = store_val[6:0];
                            else       rd = field_bus;
                        rtcfe_pkg::REG_ASEC:
                            if (is_wr) asec_next = store_val[6:0];
                            else       rd = field_bus;
                        rtcfe_pkg::REG_MIN:
                            if (is_wr) min_next = store_val[6:0];
                            else       rd = field_bus;
                        rtcfe_pkg::REG_AMIN:
                            if (is_wr) amin_next = store_val[6:0];
                            else       rd = field_bus;
                        rtcfe_pkg::REG_HOUR:
                            if (is_wr) hour_next = hour_wr_val;
                            else       rd = hour_bus;
                        rtcfe_pkg::REG_AHOUR:
                            if (is_wr) ahour_next = hour_wr_val;
                            else       rd = hour_bus;
                        rtcfe_pkg::REG_WEEKDAY:
                            if (is_wr) weekday_next = store_val[2:0];
                            else       rd = field_bus;
                        rtcfe_pkg::REG_DATE:
                            if (is_wr) date_next = store_val[5:0];
                            else       rd = field_bus;
                        rtcfe_pkg::REG_MONTH:
                            if (is_wr) month_next = store_val[4:0];
                            else       rd = field_bus;
                        rtcfe_pkg::REG_YEAR:
                            if (is_wr) year_next = store_val[7:0];
                            else       rd = field_bus;
                        rtcfe_pkg::REG_CTRL_A:
                            if (is_wr) begin
                                divider_next = item.write_data[6:4];
                                rate_next    = item.write_data[3:0];
                            end else begin
                                rd = {1'b0, divider_reg, rate_reg};
                            end
                        rtcfe_pkg::REG_CTRL_B:
                            if (is_wr) mode_next = item.write_data;
                            else       rd = mode_reg;
                        rtcfe_pkg::REG_CTRL_C:
                            if (!is_wr) begin
                                rd         = {flags_reg, 4'b0000};
                                flags_next = '0;
                                clr_flags  = 1'b1;
                            end
                        rtcfe_pkg::REG_CTRL_D:
                            if (!is_wr) rd = rtcfe_pkg::CTRL_D_VALUE;
                        default:
                            if (rtcfe_pkg::nv_hit(idx)) begin
                                if (is_wr) begin
                                    nv_wr.en   = commit;
                                    nv_wr.addr = rtcfe_pkg::nv_addr(idx);
                                    nv_wr.data = item.write_data;
                                end else begin
                                    rd = nv_rdata;
                                end
                            end
                    endcase
                end
            end
            rtcfe_pkg::CMD_ALARM: begin
                handled = 1'b1;
                if (!flags_reg[rtcfe_pkg::EF_AF]) begin
                    flags_next[rtcfe_pkg::EF_AF] = 1'b1;
                    if (mode_reg[rtcfe_pkg::MB_AIE])
                        flags_next[rtcfe_pkg::EF_IRQF] = 1'b1;
                end
            end
            rtcfe_pkg::CMD_UPDATE: begin
                handled = 1'b1;
                if (!flags_reg[rtcfe_pkg::EF_UF]) begin
                    flags_next[rtcfe_pkg::EF_UF] = 1'b1;
                    if (mode_reg[rtcfe_pkg::MB_UIE])
                        flags_next[rtcfe_pkg::EF_IRQF] = 1'b1;
                end
            end
            rtcfe_pkg::CMD_TICK: begin
                handled = 1'b1;
                if (tick_fire) begin
                    tick_next = '0;
                    if (!flags_reg[rtcfe_pkg::EF_PF]) begin
                        flags_next[rtcfe_pkg::EF_PF] = 1'b1;
                        if (mode_reg[rtcfe_pkg::MB_PIE])
                            flags_next[rtcfe_pkg::EF_IRQF] = 1'b1;
                    end
                end else begin
                    tick_next = tick_reg + 16'd1;
                end
            end
            default: ;
        endcase
    end

    assign result.read_data = rd;
    assign result.handled   = handled;
    assign result.irq_out   = flags_next[rtcfe_pkg::EF_IRQF];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sec_reg     <= 7'h00;
            min_reg     <= 7'h57;
            hour_reg    <= 6'h19;
            asec_reg    <= 7'h00;
            amin_reg    <= 7'h00;
            ahour_reg   <= 6'h00;
            weekday_reg <= 3'd5;
            date_reg    <= 6'h01;
            month_reg   <= 5'h01;
            year_reg    <= 8'h22;
            rate_reg    <= 4'd0;
            divider_reg <= 3'd0;
            mode_reg    <= rtcfe_pkg::MODE_RESET;
            flags_reg   <= 4'd0;
            tick_reg    <= 16'd0;
        end else if (commit) begin
            sec_reg     <= sec_next;
            min_reg     <= min_next;
            hour_reg    <= hour_next;
            asec_reg    <= asec_next;
            amin_reg    <= amin_next;
            ahour_reg   <= ahour_next;
            weekday_reg <= weekday_next;
            date_reg    <= date_next;
            month_reg   <= month_next;
            year_reg    <= year_next;
            rate_reg    <= rate_next;
            divider_reg <= divider_next;
            mode_reg    <= mode_next;
            flags_reg   <= flags_next;
            tick_reg    <= tick_next;
        end
    end

    // IRQF only comes up together with a newly raised event flag
    a_irq_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && flags_next[rtcfe_pkg::EF_IRQF] && !flags_reg[rtcfe_pkg::EF_IRQF])
        |-> (flags_next[2:0] != flags_reg[2:0]))
        else $error("IRQF set without a new event flag");

    a_ctrl_c_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && clr_flags) |=> (flags_reg == 4'd0))
        else $error("control C read did not clear the flags");

endmodule

`default_nettype wire

### rtl/cmos_rtc_register_front_end_top.sv
// Top level of the RTC register front end: input stage, result register, submodules.
// A transaction accepted into stage 1 is handled by rtcfe_regs, and its result is registered
// in the result register that drives rsp; a stall on rsp_ready holds it in stage 1.
// Throughput: one transaction per cycle while rsp_ready does not stall; stage 1 holds the item
// while the NVRAM read completes, the result register decouples the response side.
// Reset (rst_n, async low): time/date/control registers go to power-on values,
// NVRAM reads zero through per-byte valid bits; the block is usable right after reset.
`timescale 1ns / 1ps
`default_nettype none

module cmos_rtc_register_front_end_top (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire rtcfe_pkg::req_t req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output rtcfe_pkg::rsp_t      rsp
);

    logic              s1_valid_reg, s1_valid_next;
    rtcfe_pkg::req_t   s1_item_reg;
    logic              out_valid_reg, out_valid_next;
    rtcfe_pkg::rsp_t   out_item_reg;
    logic              accept;
    logic              advance;
    rtcfe_pkg::nv_rd_t nv_rd;
    rtcfe_pkg::nv_wr_t nv_wr;
    logic [7:0]        nv_rdata;
    rtcfe_pkg::rsp_t   result;

    assign advance   = s1_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || advance;
    assign accept    = req_valid && req_ready;

    // NVRAM read goes out with the transaction so data lines up with stage 1
    assign nv_rd.en   = accept && (req.cmd == rtcfe_pkg::CMD_READ) && rtcfe_pkg::bus_ok(req)
                        && rtcfe_pkg::nv_hit(req.addr[8:2]);
    assign nv_rd.addr = rtcfe_pkg::nv_addr(req.addr[8:2]);

    rtcfe_nvram u_nvram (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (nv_rd),
        .wr    (nv_wr),
        .rdata (nv_rdata)
    );

    rtcfe_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .commit   (advance),
        .item     (s1_item_reg),
        .nv_rdata (nv_rdata),
        .result   (result),
        .nv_wr    (nv_wr)
    );

    always_comb
    begin
        s1_valid_next  = accept || (s1_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= req;
        if (advance)
            out_item_reg <= result;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("stage 1 transaction lost while stalled");

endmodule

`default_nettype wire

### sim/cmos_rtc_register_front_end_top_tb.sv
// Self-checking testbench for the RTC register front end: directed and random transactions.
`timescale 1ns / 1ps

module cmos_rtc_register_front_end_top_tb;

    import rtcfe_pkg::*;

    localparam int          CLK_PERIOD    = 12;
    localparam int          RESET_CYCLES  = 7;
    localparam int          RANDOM_ITEMS  = 1700;
    localparam int          BURST_ITEMS   = 300;
    localparam int          IDLE_PCT      = 11;
    localparam int          DRAIN_CYCLES  = 10;
    localparam longint      LIMIT_NS      = 10_000_000;

    localparam logic [2:0]  SIZE_BYTE     = 3'd1;
    localparam logic [2:0]  SIZE_WORD     = 3'd4;
    localparam logic [2:0]  CMD_RSVD_LAST = 3'd7;
    localparam int unsigned REG_SPACE     = 128;
    localparam int unsigned HOUR_TWELVE   = 'h12;
    localparam int unsigned HOUR_PM       = 'h80;
    localparam int unsigned HOUR_MASK     = 'h3f;
    localparam logic [6:0]  NVRAM_LAST    = 7'd127;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    cmos_rtc_register_front_end_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // predicted device state
    logic [7:0]  clock_q [10];
    logic [7:0]  nvram_q [NVRAM_BYTES];
    logic [3:0]  rate_q;
    logic [2:0]  divider_q;
    logic [7:0]  mode_q;
    logic [3:0]  flags_q;
    logic [15:0] tick_q;

    rsp_t expected_q [$];
    bit   no_idle         = 1'b0;
    int   error_count     = 0;
    int   items_sent      = 0;
    int   results_checked = 0;
    int   bus_rejects     = 0;
    int   ticks_fired     = 0;
    int   flag_reads      = 0;

    function automatic int unsigned bin2bcd(input int unsigned v);
        return (v / 10) * 16 + v % 10;
    endfunction

    function automatic int unsigned bcd2bin(input int unsigned v);
        return (v / 16) * 10 + v % 16;
    endfunction

    function automatic int unsigned to_field(input int unsigned v, input logic dm);
        return dm ? bin2bcd(v) : v;
    endfunction

    function automatic int unsigned from_field(input int unsigned v, input logic dm);
        return dm ? bcd2bin(v) : v;
    endfunction

    function automatic int unsigned field_mask(input int unsigned idx);
        case (idx)
            REG_SEC, REG_ASEC, REG_MIN, REG_AMIN: return 'h7f;
            REG_WEEKDAY:                          return 'h07;
            REG_DATE:                             return 'h3f;
            REG_MONTH:                            return 'h1f;
            default:                              return 'hff;
        endcase
    endfunction

    function automatic int unsigned tick_limit(input logic [3:0] rate);
        case (rate)
            4'd1, 4'd8:  return 124;
            4'd2, 4'd9:  return 249;
            4'd3:        return 3;
            4'd4:        return 7;
            4'd5:        return 15;
            4'd6:        return 30;
            4'd7:        return 62;
            4'd10:       return 499;
            4'd11:       return 999;
            4'd12:       return 1999;
            4'd13:       return 3999;
            4'd14:       return 7999;
            4'd15:       return 15999;
            default:     return 'hffff;
        endcase
    endfunction

    task automatic rtc_state_reset();
        clock_q = '{8'h00, 8'h00, 8'h57, 8'h00, 8'h19, 8'h00, 8'h05, 8'h01, 8'h01, 8'h22};
        foreach (nvram_q[i])
            nvram_q[i] = 8'h00;
        rate_q    = '0;
        divider_q = '0;
        mode_q    = MODE_RESET;
        flags_q   = '0;
        tick_q    = '0;
    endtask

    // flag is set only on a clear-to-set change; IRQF follows the enable at that moment
    function automatic void raise_event(input int flag, input int enable);
        if (!flags_q[flag]) begin
            flags_q[flag] = 1'b1;
            if (mode_q[enable])
                flags_q[EF_IRQF] = 1'b1;
        end
    endfunction

    function automatic rsp_t rtc_predict(input req_t r);
        rsp_t        o;
        int unsigned idx;
        int unsigned t;
        int unsigned rd;
        logic        wr;
        logic        dm;
        logic        h24;
        o   = '0;
        rd  = 0;
        dm  = mode_q[MB_DM];
        h24 = mode_q[MB_24H];
        wr  = (r.cmd == CMD_WRITE);
        idx = int'(r.addr) >> 2;
        case (r.cmd)
            CMD_READ, CMD_WRITE: begin
                if (r.access_size != SIZE_BYTE || r.addr[1:0] != 2'b00 || idx >= REG_SPACE) begin
                    bus_rejects++;
                end else begin
                    o.handled = 1'b1;
                    if (idx == REG_HOUR || idx == REG_AHOUR) begin
                        if (wr) begin
                            t = to_field(int'(r.write_data[6:0]), dm);
                            if (!h24) begin
                                if (t == HOUR_TWELVE)
                                    t = 0;
                                if (r.write_data[7])
                                    t = bin2bcd(bcd2bin(t) + 12);
                            end
                            clock_q[idx] = 8'(t & HOUR_MASK);
                        end else begin
                            t = clock_q[idx] & HOUR_MASK;
                            if (!h24) begin
                                if (t == 0)
                                    t = HOUR_TWELVE;
                                else if (t == HOUR_TWELVE)
                                    t = HOUR_PM | HOUR_TWELVE;
                                else if (t > HOUR_TWELVE)
                                    t = HOUR_PM | (bin2bcd(bcd2bin(t) - 12) & 'h7f);
                            end
                            rd = (t & HOUR_PM) | from_field(t & 'h7f, dm);
                        end
                    end else if (idx < REG_CTRL_A) begin
                        if (wr)
                            clock_q[idx] = 8'(to_field(r.write_data, dm) & field_mask(idx));
                        else
                            rd = from_field(clock_q[idx], dm);
                    end else if (idx == REG_CTRL_A) begin
                        if (wr) begin
                            divider_q = r.write_data[6:4];
                            rate_q    = r.write_data[3:0];
                        end else begin
                            rd = {1'b0, divider_q, rate_q};
                        end
                    end else if (idx == REG_CTRL_B) begin
                        if (wr)
                            mode_q = r.write_data;
                        else
                            rd = mode_q;
                    end else if (idx == REG_CTRL_C) begin
                        if (!wr) begin
                            rd = {flags_q, 4'h0};
                            flags_q = '0;
                            flag_reads++;
                        end
                    end else if (idx == REG_CTRL_D) begin
                        if (!wr)
                            rd = CTRL_D_VALUE;
                    end else if (idx - NVRAM_BASE < NVRAM_BYTES) begin
                        if (wr)
                            nvram_q[idx - NVRAM_BASE] = r.write_data;
                        else
                            rd = nvram_q[idx - NVRAM_BASE];
                    end
                end
            end
            CMD_ALARM: begin
                o.handled = 1'b1;
                raise_event(EF_AF, MB_AIE);
            end
            CMD_UPDATE: begin
                o.handled = 1'b1;
                raise_event(EF_UF, MB_UIE);
            end
            CMD_TICK: begin
                o.handled = 1'b1;
                if (tick_q >= tick_limit(rate_q)) begin
                    tick_q = '0;
                    ticks_fired++;
                    raise_event(EF_PF, MB_PIE);
                end else begin
                    tick_q = tick_q + 16'd1;
                end
            end
            default: bus_rejects++;
        endcase
        o.read_data = 8'(rd);
        o.irq_out   = flags_q[EF_IRQF];
        return o;
    endfunction

    function automatic logic [23:0] reg_addr(input logic [6:0] idx);
        return {15'd0, idx, 2'b00};
    endfunction

    function automatic req_t make_req(input logic [2:0] c, input logic [23:0] a,
                                      input logic [2:0] s, input logic [7:0] d);
        req_t r;
        r.cmd         = c;
        r.addr        = a;
        r.access_size = s;
        r.write_data  = d;
        return r;
    endfunction

    function automatic req_t bus_item(input cmd_e c, input logic [6:0] idx, input logic [7:0] d);
        return make_req(c, reg_addr(idx), SIZE_BYTE, d);
    endfunction

    // entered and left just after a rising edge; valid stays high on return
    task automatic send_item(input req_t item);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(negedge clk);
        while (!req_ready);
        expected_q.push_back(rtc_predict(item));
        items_sent++;
        @(posedge clk);
    endtask

    task automatic wait_all_results();
        req_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_reset_values();
        send_item(bus_item(CMD_READ, REG_MIN, 8'h00));
        send_item(bus_item(CMD_READ, REG_HOUR, 8'h00));
        send_item(bus_item(CMD_READ, REG_YEAR, 8'h00));
        send_item(bus_item(CMD_READ, REG_CTRL_A, 8'h00));
        send_item(bus_item(CMD_READ, REG_CTRL_B, 8'h00));
        send_item(bus_item(CMD_READ, REG_CTRL_D, 8'h00));
    endtask

    // rejected accesses must leave the seconds register alone
    task automatic test_bus_decode();
        send_item(make_req(CMD_WRITE, reg_addr(REG_SEC), 3'd0, 8'hff));
        send_item(make_req(CMD_WRITE, reg_addr(REG_SEC), SIZE_WORD, 8'hff));
        send_item(make_req(CMD_WRITE, reg_addr(REG_SEC) | 24'd1, SIZE_BYTE, 8'hff));
        send_item(make_req(CMD_READ, reg_addr(NVRAM_LAST) + 24'd4, SIZE_BYTE, 8'h00));
        send_item(make_req(CMD_WRITE, 24'hff_ffff, SIZE_BYTE, 8'hff));
        send_item(make_req(CMD_RSVD_LAST, reg_addr(REG_SEC), SIZE_BYTE, 8'hff));
        send_item(bus_item(CMD_READ, REG_SEC, 8'h00));
    endtask

    // 12 PM and 12 AM in binary 12-hour mode, then the PM hour seen in BCD
    task automatic test_hour_modes();
        send_item(bus_item(CMD_WRITE, REG_CTRL_B, 8'(1 << MB_DM)));
        send_item(bus_item(CMD_WRITE, REG_HOUR, 8'(HOUR_PM) | 8'd12));
        send_item(bus_item(CMD_READ, REG_HOUR, 8'h00));
        send_item(bus_item(CMD_WRITE, REG_AHOUR, 8'd12));
        send_item(bus_item(CMD_READ, REG_AHOUR, 8'h00));
        send_item(bus_item(CMD_WRITE, REG_CTRL_B, 8'h00));
        send_item(bus_item(CMD_READ, REG_HOUR, 8'h00));
    endtask

    task automatic test_events();
        send_item(bus_item(CMD_WRITE, REG_CTRL_B, 8'((1 << MB_AIE) | (1 << MB_UIE))));
        send_item(make_req(CMD_ALARM, '0, SIZE_BYTE, 8'h00));
        send_item(make_req(CMD_UPDATE, '0, SIZE_BYTE, 8'h00));
        send_item(bus_item(CMD_WRITE, REG_CTRL_C, 8'hff));
        send_item(bus_item(CMD_READ, REG_CTRL_C, 8'h00));
        send_item(bus_item(CMD_READ, REG_CTRL_C, 8'h00));
    endtask

    task automatic test_nvram();
        send_item(bus_item(CMD_WRITE, NVRAM_LAST, 8'hff));
        send_item(bus_item(CMD_READ, NVRAM_LAST, 8'h00));
        send_item(bus_item(CMD_READ, NVRAM_BASE, 8'h00));
    endtask

    function automatic req_t random_item();
        req_t        r;
        int unsigned pick;
        logic [6:0]  idx;
        r.cmd         = 3'($urandom_range(7));
        r.addr        = 24'($urandom);
        r.access_size = 3'($urandom_range(7));
        r.write_data  = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 62) begin
            r.cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
            if ($urandom_range(99) < 70)
                idx = 7'($urandom_range(REG_CTRL_D));
            else
                idx = 7'($urandom_range(NVRAM_LAST, NVRAM_BASE));
            r.addr        = reg_addr(idx);
            r.access_size = SIZE_BYTE;
            case ($urandom_range(9))
                0:       r.write_data = 8'h00;
                1:       r.write_data = 8'hff;
                default: ;
            endcase
            // favor fast periodic rates so the tick actually fires
            if (idx == REG_CTRL_A && $urandom_range(3) != 0)
                r.write_data[3:0] = 4'($urandom_range(7, 3));
        end else if (pick < 88) begin
            case ($urandom_range(5))
                0:       r.cmd = CMD_ALARM;
                1:       r.cmd = CMD_UPDATE;
                default: r.cmd = CMD_TICK;
            endcase
        end else if ($urandom_range(1)) begin
            r.addr = 24'($urandom_range(REG_SPACE * 4 - 1));
        end
        return r;
    endfunction

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            no_idle = (i < BURST_ITEMS);
            if (i == count / 2)
                wait_all_results();
            send_item(random_item());
        end
        no_idle = 1'b0;
    endtask

    always @(posedge clk)
        rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

    function automatic void report_field(input string name, input int want, input int got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // a transaction seen at the falling edge completes at the next rising edge
    always @(negedge clk) begin : result_check
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t ns: result with nothing pending, actual %h/%b/%b", $time,
                         rsp.read_data, rsp.handled, rsp.irq_out);
                error_count++;
            end else begin
                want = expected_q.pop_front();
                results_checked++;
                report_field("read_data", want.read_data, rsp.read_data);
                report_field("handled", want.handled, rsp.handled);
                report_field("irq_out", want.irq_out, rsp.irq_out);
            end
        end
    end

    initial begin
        rtc_state_reset();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_bus_decode();
        test_hour_modes();
        test_events();
        test_nvram();
        wait_all_results();
        test_random(RANDOM_ITEMS);
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_q.size() != 0) begin
            $display("%0d results never arrived", expected_q.size());
            error_count++;
        end
        $display("%0d transactions sent (%0d rejected or unused), %0d results checked",
                 items_sent, bus_rejects, results_checked);
        $display("%0d periodic ticks fired, %0d flag register reads, %0d mismatches",
                 ticks_fired, flag_reads, error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("timeout with %0d results outstanding", expected_q.size());
        $display("simulation failed");
        $finish;
    end

endmodule
